// ----- rtl/lrsf_pkg.sv -----
package lrsf_pkg;

  // Defaults for the top-level parameters
  localparam int COORD_BITS_DEF = 19;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int SECTORS_DEF    = 3;

  // Register file layout
  localparam int MAX_SECTORS = 3;
  localparam int RANGE_BITS  = 18;
  localparam int RANGE_SQ_W  = 2 * RANGE_BITS;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RANGE = 3'd0,
    REG_MAX_RANGE = 3'd1,
    REG_SEC0_LOW  = 3'd2,
    REG_SEC0_HIGH = 3'd3,
    REG_SEC1_LOW  = 3'd4,
    REG_SEC1_HIGH = 3'd5,
    REG_SEC2_LOW  = 3'd6,
    REG_SEC2_HIGH = 3'd7
  } cfg_reg_e;

  // Reset values
  localparam logic [RANGE_BITS-1:0] MIN_RANGE_RST = 18'd100;
  localparam logic [RANGE_BITS-1:0] MAX_RANGE_RST = 18'd20000;
  localparam logic [31:0]           SEC_LOW_RST   = 32'h0000_7FFF;
  localparam logic [31:0]           SEC_HIGH_RST  = 32'h0000_8000;

  // Angle datapath: 2^31 is pi in the accumulator
  localparam int CORDIC_STAGES = 28;
  localparam int SCALE_BITS    = 16;
  localparam int ZW            = 34;
  localparam int RANGE_LAT     = 2;
  localparam int PIPE_LAT      = CORDIC_STAGES + 2;

  // Arctangent of 2^-i in accumulator units
  function automatic logic [31:0] atan_rom(input int unsigned idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      24: v = 32'd41;
      25: v = 32'd20;
      26: v = 32'd10;
      27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lrsf_cfg_regs.sv -----
module lrsf_cfg_regs
  import lrsf_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int CFG_W      = RANGE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_data_i,
  output logic [RANGE_SQ_W-1:0]        min_sq_o,
  output logic [RANGE_SQ_W-1:0]        max_sq_o,
  output logic signed [ANGLE_BITS-1:0] sec_lo_o [MAX_SECTORS],
  output logic signed [ANGLE_BITS-1:0] sec_hi_o [MAX_SECTORS]
);

  logic [RANGE_BITS-1:0]        min_q, max_q;
  logic [RANGE_SQ_W-1:0]        min_sq_q, max_sq_q;
  logic signed [ANGLE_BITS-1:0] lo_q [MAX_SECTORS];
  logic signed [ANGLE_BITS-1:0] hi_q [MAX_SECTORS];
  logic [ANGLE_BITS-1:0]        ang_wr;

  assign ang_wr = cfg_data_i[ANGLE_BITS-1:0];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RANGE_RST;
      max_q <= MAX_RANGE_RST;
      for (int k = 0; k < MAX_SECTORS; k++) begin
        lo_q[k] <= ANGLE_BITS'(SEC_LOW_RST);
        hi_q[k] <= ANGLE_BITS'(SEC_HIGH_RST);
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_RANGE: min_q    <= cfg_data_i[RANGE_BITS-1:0];
        REG_MAX_RANGE: max_q    <= cfg_data_i[RANGE_BITS-1:0];
        REG_SEC0_LOW:  lo_q[0]  <= ang_wr;
        REG_SEC0_HIGH: hi_q[0]  <= ang_wr;
        REG_SEC1_LOW:  lo_q[1]  <= ang_wr;
        REG_SEC1_HIGH: hi_q[1]  <= ang_wr;
        REG_SEC2_LOW:  lo_q[2]  <= ang_wr;
        REG_SEC2_HIGH: hi_q[2]  <= ang_wr;
        default: ;
      endcase
    end
  end

  // Square the range limits in a register, off the point path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sq_q <= RANGE_SQ_W'(MIN_RANGE_RST) * RANGE_SQ_W'(MIN_RANGE_RST);
      max_sq_q <= RANGE_SQ_W'(MAX_RANGE_RST) * RANGE_SQ_W'(MAX_RANGE_RST);
    end else begin
      min_sq_q <= min_q * min_q;
      max_sq_q <= max_q * max_q;
    end
  end

  assign min_sq_o = min_sq_q;
  assign max_sq_o = max_sq_q;
  assign sec_lo_o = lo_q;
  assign sec_hi_o = hi_q;

endmodule

// ----- rtl/lrsf_range.sv -----
module lrsf_range
  import lrsf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  input  logic [RANGE_SQ_W-1:0]        min_sq_i,
  input  logic [RANGE_SQ_W-1:0]        max_sq_i,
  output logic                         in_range_o
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int R2_W  = SQ_W + 1;
  localparam int CMP_W = (R2_W > RANGE_SQ_W) ? R2_W : RANGE_SQ_W;

  logic [COORD_BITS-1:0] ax, ay;
  logic [SQ_W-1:0]       sqx_d, sqy_d, sqx_q, sqy_q;
  logic [R2_W-1:0]       r2;
  logic [CMP_W-1:0]      r2_ext, min_ext, max_ext;
  logic                  in_range_d, in_range_q;

  // Stage one: magnitudes and squares
  always_comb begin
    ax    = x_i[COORD_BITS-1] ? (~x_i + 1'b1) : x_i;
    ay    = y_i[COORD_BITS-1] ? (~y_i + 1'b1) : y_i;
    sqx_d = SQ_W'(ax) * SQ_W'(ax);
    sqy_d = SQ_W'(ay) * SQ_W'(ay);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
    end
  end

  // Stage two: sum and compare against the squared limits
  always_comb begin
    r2         = R2_W'(sqx_q) + R2_W'(sqy_q);
    r2_ext     = CMP_W'(r2);
    min_ext    = CMP_W'(min_sq_i);
    max_ext    = CMP_W'(max_sq_i);
    in_range_d = !(r2_ext < min_ext) && !(r2_ext > max_ext);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_range_q <= in_range_d;
    end
  end

  assign in_range_o = in_range_q;

endmodule

// ----- rtl/lrsf_cordic.sv -----
module lrsf_cordic
  import lrsf_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] x_i,
  input  logic signed [COORD_BITS-1:0] y_i,
  output logic signed [ANGLE_BITS-1:0] angle_o
);

  // Scaled coordinate plus sign and CORDIC growth
  localparam int W = COORD_BITS + SCALE_BITS + 2;

  localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1073741824);
  localparam logic signed [ZW-1:0] Z_ROUND   = ZW'(64'sd1) <<< (31 - ANGLE_BITS);
  localparam logic signed [ZW-1:0] A_MAX_Z   = (ZW'(64'sd1) <<< (ANGLE_BITS - 1)) - 1;
  localparam logic signed [ZW-1:0] A_MIN_Z   = -(ZW'(64'sd1) <<< (ANGLE_BITS - 1));
  localparam logic signed [ANGLE_BITS-1:0] A_MAX = A_MAX_Z[ANGLE_BITS-1:0];
  localparam logic signed [ANGLE_BITS-1:0] A_MIN = A_MIN_Z[ANGLE_BITS-1:0];

  logic signed [W-1:0]  cx_q [CORDIC_STAGES+1];
  logic signed [W-1:0]  cy_q [CORDIC_STAGES+1];
  logic signed [ZW-1:0] z_q  [CORDIC_STAGES+1];
  logic                 yz_q [CORDIC_STAGES+1];
  logic                 xn_q [CORDIC_STAGES+1];

  logic signed [W-1:0]  xs, ys, cx0_d, cy0_d;
  logic signed [ZW-1:0] z0_d;

  // Pre-rotation into the right half plane
  always_comb begin
    xs    = W'($signed({x_i, {SCALE_BITS{1'b0}}}));
    ys    = W'($signed({y_i, {SCALE_BITS{1'b0}}}));
    cx0_d = xs;
    cy0_d = ys;
    z0_d  = '0;
    if (x_i[COORD_BITS-1]) begin
      if (ys > 0) begin
        cx0_d = ys;
        cy0_d = -xs;
        z0_d  = Z_QUARTER;
      end else begin
        cx0_d = -ys;
        cy0_d = xs;
        z0_d  = -Z_QUARTER;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= cx0_d;
      cy_q[0] <= cy0_d;
      z_q[0]  <= z0_d;
      yz_q[0] <= (y_i == '0);
      xn_q[0] <= x_i[COORD_BITS-1];
    end
  end

  // One micro-rotation per stage
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    localparam logic signed [ZW-1:0] AT = ZW'(atan_rom(k));
    logic signed [W-1:0]  dx, dy, cx_d, cy_d;
    logic signed [ZW-1:0] z_d;

    always_comb begin
      dx = cy_q[k] >>> k;
      dy = cx_q[k] >>> k;
      if (cy_q[k] > 0) begin
        cx_d = cx_q[k] + dx;
        cy_d = cy_q[k] - dy;
        z_d  = z_q[k] + AT;
      end else begin
        cx_d = cx_q[k] - dx;
        cy_d = cy_q[k] + dy;
        z_d  = z_q[k] - AT;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cx_q[k+1] <= cx_d;
        cy_q[k+1] <= cy_d;
        z_q[k+1]  <= z_d;
        yz_q[k+1] <= yz_q[k];
        xn_q[k+1] <= xn_q[k];
      end
    end
  end

  // Round, saturate and resolve the axis cases
  logic signed [ZW-1:0]         zr, zs;
  logic signed [ANGLE_BITS-1:0] angle_d, angle_q;

  always_comb begin
    zr = z_q[CORDIC_STAGES] + Z_ROUND;
    zs = zr >>> (32 - ANGLE_BITS);
    if (yz_q[CORDIC_STAGES]) begin
      angle_d = xn_q[CORDIC_STAGES] ? A_MAX : '0;
    end else if (zs > A_MAX_Z) begin
      angle_d = A_MAX;
    end else if (zs < A_MIN_Z) begin
      angle_d = A_MIN;
    end else begin
      angle_d = zs[ANGLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      angle_q <= angle_d;
    end
  end

  assign angle_o = angle_q;

endmodule

// ----- rtl/lidar_range_sector_point_filter_unit.sv -----
// Range and sector crop filter for a stream of lidar points.
//
// Input beats carry one point: x, y, z, reflectivity, tag, line and time in
// s_axis_tdata, the end-of-frame marker in s_axis_tlast. Every point comes
// out once on the master side with the same fields and the end-of-frame
// marker in m_axis_tlast; m_axis_tuser is the keep flag. A point is dropped
// when its planar range is outside [min_range, max_range] (squared compare)
// or when its atan2 angle lies inside an excluded sector.
//
// From the accepting edge to m_axis_tvalid a point passes a 28-stage
// pipelined CORDIC plus pre-rotation and rounding stages, then the sector
// compare into the output register. Unless stalled, one point is taken every
// cycle. The whole pipeline advances on one enable; when the receiver stalls
// with a result in the output register, every stage holds and s_axis_tready
// drops in the same cycle, so nothing is lost or repeated. Reset clears the
// valid bits and loads the register defaults. Registers must be written via
// cfg_we_i/cfg_idx_i/cfg_data_i only while the block is idle (unchecked).
module lidar_range_sector_point_filter_unit
  import lrsf_pkg::*;
#(
  parameter int  COORD_BITS = COORD_BITS_DEF,
  parameter int  ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int  SECTORS    = SECTORS_DEF,
  localparam int TDATA_W    = ((3 * COORD_BITS + 56 + 7) / 8) * 8,
  localparam int CFG_W      = (ANGLE_BITS > RANGE_BITS) ? ANGLE_BITS : RANGE_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // Point input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // pos_x, pos_y, pos_z, reflect, tag_byte, scan_line, time_offset, zero pad
  input  logic [TDATA_W-1:0]   s_axis_tdata,
  input  logic                 s_axis_tlast,
  // Point output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // out_x, out_y, out_z, out_reflect, out_tag, out_line, out_time, zero pad
  output logic [TDATA_W-1:0]   m_axis_tdata,
  // keep
  output logic                 m_axis_tuser,
  output logic                 m_axis_tlast
);

  localparam int FW     = 3 * COORD_BITS + 56;
  localparam int RNG_DL = PIPE_LAT - RANGE_LAT;

  logic                         en;
  logic [RANGE_SQ_W-1:0]        min_sq, max_sq;
  logic signed [ANGLE_BITS-1:0] sec_lo [MAX_SECTORS];
  logic signed [ANGLE_BITS-1:0] sec_hi [MAX_SECTORS];
  logic signed [COORD_BITS-1:0] pos_x, pos_y;
  logic                         in_range;
  logic signed [ANGLE_BITS-1:0] angle;

  // Advance the pipeline whenever the output register is free or drains
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign pos_x = s_axis_tdata[COORD_BITS-1:0];
  assign pos_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];

  lrsf_cfg_regs #(
    .ANGLE_BITS (ANGLE_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .min_sq_o   (min_sq),
    .max_sq_o   (max_sq),
    .sec_lo_o   (sec_lo),
    .sec_hi_o   (sec_hi)
  );

  lrsf_range #(
    .COORD_BITS (COORD_BITS)
  ) u_range (
    .clk_i      (clk_i),
    .en_i       (en),
    .x_i        (pos_x),
    .y_i        (pos_y),
    .min_sq_i   (min_sq),
    .max_sq_i   (max_sq),
    .in_range_o (in_range)
  );

  lrsf_cordic #(
    .COORD_BITS (COORD_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (pos_x),
    .y_i     (pos_y),
    .angle_o (angle)
  );

  // Valid bits travel alongside the angle pipeline
  logic vld_q [PIPE_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
      for (int i = 1; i < PIPE_LAT; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Delay the pass-through fields and the range verdict
  logic [FW-1:0] pay_q  [PIPE_LAT];
  logic          last_q [PIPE_LAT];
  logic          rng_q  [RNG_DL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0]  <= s_axis_tdata[FW-1:0];
      last_q[0] <= s_axis_tlast;
      for (int i = 1; i < PIPE_LAT; i++) begin
        pay_q[i]  <= pay_q[i-1];
        last_q[i] <= last_q[i-1];
      end
      rng_q[0] <= in_range;
      for (int i = 1; i < RNG_DL; i++) begin
        rng_q[i] <= rng_q[i-1];
      end
    end
  end

  // Sector test and keep decision
  logic hit, keep_d;

  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < SECTORS; k++) begin
      hit = hit | ((angle >= sec_lo[k]) && (angle <= sec_hi[k]));
    end
    keep_d = rng_q[RNG_DL-1] && !hit;
  end

  // Output register
  logic               m_vld_q, m_keep_q, m_last_q;
  logic [TDATA_W-1:0] m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= vld_q[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= TDATA_W'(pay_q[PIPE_LAT-1]);
      m_last_q <= last_q[PIPE_LAT-1];
      m_keep_q <= keep_d;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_keep_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// ----- rtl/lrsf_checker.sv -----
module lrsf_checker
  import lrsf_pkg::*;
#(
  parameter int TDATA_W = 120
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic               m_axis_tuser,
  input logic               m_axis_tlast
);

  localparam int CNT_W = $clog2(PIPE_LAT + 2) + 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(PIPE_LAT + 1);

  logic             in_beat, out_beat;
  logic [CNT_W-1:0] cnt_q;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  // Track points in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_beat && !out_beat) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled output beat changed");

  // Input side follows the output register
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready out of step with output stall");

  // No result without a point in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("output beat with no point in flight");

  // Pipeline never holds more than its depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CAP)
    else $error("more points in flight than pipeline stages");

endmodule

bind lidar_range_sector_point_filter_unit lrsf_checker #(
  .TDATA_W (TDATA_W)
) u_lrsf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/lrsf_keep_checker.sv -----
module lrsf_keep_checker
  import lrsf_pkg::*;
#(
  parameter int TDATA_W = 120,
  parameter int CFG_W   = 18
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [TDATA_W-1:0]   m_axis_tdata,
  input  logic                 m_axis_tuser,
  input  logic                 m_axis_tlast,
  output int                   mismatch_cnt_o,
  output int                   in_flight_o,
  output int                   checked_cnt_o,
  output int                   kept_cnt_o
);

  localparam int CW    = COORD_BITS_DEF;
  localparam int ABITS = ANGLE_BITS_DEF;
  localparam int PAD_W = TDATA_W - 3 * CW - 56;

  // Beat layout, x in the lowest bits
  typedef struct packed {
    logic [PAD_W-1:0]     pad;
    logic [31:0]          tofs;
    logic [7:0]           line;
    logic [7:0]           tag;
    logic [7:0]           refl;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] x;
  } point_word_t;

  typedef struct {
    logic        keep;
    point_word_t word;
    logic        last;
  } filtered_point_t;

  // Local copy of the register file
  logic [RANGE_BITS-1:0]   min_range_q;
  logic [RANGE_BITS-1:0]   max_range_q;
  logic signed [ABITS-1:0] sec_lo_q [MAX_SECTORS];
  logic signed [ABITS-1:0] sec_hi_q [MAX_SECTORS];

  filtered_point_t filtered_q [$];
  filtered_point_t want;
  point_word_t     in_word;
  point_word_t     out_word;
  int              mismatches;
  int              checked;
  int              kept;

  // Arctangent of 2^-i, pi is 2^31
  function automatic longint arctan_step(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      24: return 41;
      25: return 20;
      26: return 10;
      27: return 5;
      default: return 0;
    endcase
  endfunction

  // Vectoring CORDIC giving atan2(y, x) as a signed binary angle
  function automatic longint binary_bearing(input longint x, input longint y);
    longint amax;
    longint amin;
    longint cx;
    longint cy;
    longint dx;
    longint dy;
    longint t;
    longint z;
    longint r;
    int     i;
    amax = (longint'(1) << (ABITS - 1)) - 1;
    amin = -(longint'(1) << (ABITS - 1));
    if (y == 0) return (x >= 0) ? 0 : amax;
    cx = x * 65536;
    cy = y * 65536;
    z  = 0;
    // Bring the vector into the right half-plane first
    if (cx < 0) begin
      t = cx;
      if (cy > 0) begin
        cx = cy;
        cy = -t;
        z  = longint'(1) << 30;
      end else begin
        cx = -cy;
        cy = t;
        z  = -(longint'(1) << 30);
      end
    end
    for (i = 0; i < CORDIC_STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + arctan_step(i);
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - arctan_step(i);
      end
    end
    r = (z + (longint'(1) << (31 - ABITS))) >>> (32 - ABITS);
    if (r > amax) r = amax;
    if (r < amin) r = amin;
    return r;
  endfunction

  // Range window first, then the excluded sectors
  function automatic logic predict_keep(input longint x, input longint y);
    longint r2;
    longint lo2;
    longint hi2;
    longint a;
    int     k;
    r2  = x * x + y * y;
    lo2 = longint'(min_range_q) * longint'(min_range_q);
    hi2 = longint'(max_range_q) * longint'(max_range_q);
    if (r2 < lo2 || r2 > hi2) return 1'b0;
    a = binary_bearing(x, y);
    for (k = 0; k < SECTORS_DEF; k++) begin
      if (a >= longint'(sec_lo_q[k]) && a <= longint'(sec_hi_q[k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic note_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q = MIN_RANGE_RST;
      max_range_q = MAX_RANGE_RST;
      for (int k = 0; k < MAX_SECTORS; k++) begin
        sec_lo_q[k] = SEC_LOW_RST[ABITS-1:0];
        sec_hi_q[k] = SEC_HIGH_RST[ABITS-1:0];
      end
      filtered_q.delete();
      mismatches = 0;
      checked    = 0;
      kept       = 0;
    end else begin
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MIN_RANGE: min_range_q = cfg_data_i[RANGE_BITS-1:0];
          REG_MAX_RANGE: max_range_q = cfg_data_i[RANGE_BITS-1:0];
          REG_SEC0_LOW:  sec_lo_q[0] = cfg_data_i[ABITS-1:0];
          REG_SEC0_HIGH: sec_hi_q[0] = cfg_data_i[ABITS-1:0];
          REG_SEC1_LOW:  sec_lo_q[1] = cfg_data_i[ABITS-1:0];
          REG_SEC1_HIGH: sec_hi_q[1] = cfg_data_i[ABITS-1:0];
          REG_SEC2_LOW:  sec_lo_q[2] = cfg_data_i[ABITS-1:0];
          REG_SEC2_HIGH: sec_hi_q[2] = cfg_data_i[ABITS-1:0];
          default: ;
        endcase
      end

      // Compare an output beat with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        out_word = point_word_t'(m_axis_tdata);
        if (filtered_q.size() == 0) begin
          $error("output beat with no point outstanding");
          mismatches++;
        end else begin
          want = filtered_q.pop_front();
          note_field("keep", want.keep, m_axis_tuser);
          note_field("out_x", $signed(want.word.x), $signed(out_word.x));
          note_field("out_y", $signed(want.word.y), $signed(out_word.y));
          note_field("out_z", $signed(want.word.z), $signed(out_word.z));
          note_field("out_reflect", want.word.refl, out_word.refl);
          note_field("out_tag", want.word.tag, out_word.tag);
          note_field("out_line", want.word.line, out_word.line);
          note_field("out_time", want.word.tofs, out_word.tofs);
          note_field("out_last", want.last, m_axis_tlast);
          checked++;
          if (want.keep) kept++;
        end
      end

      // Predict every input beat
      if (s_axis_tvalid && s_axis_tready) begin
        in_word   = point_word_t'(s_axis_tdata);
        want.word = in_word;
        want.last = s_axis_tlast;
        want.keep = predict_keep(longint'($signed(in_word.x)), longint'($signed(in_word.y)));
        filtered_q.insert(filtered_q.size(), want);
      end
    end
    mismatch_cnt_o <= mismatches;
    in_flight_o    <= filtered_q.size();
    checked_cnt_o  <= checked;
    kept_cnt_o     <= kept;
  end

endmodule

// ----- bench/tb.sv -----
module tb;
  import lrsf_pkg::*;

  localparam int     CW          = COORD_BITS_DEF;
  localparam int     ABITS       = ANGLE_BITS_DEF;
  localparam int     TDATA_W     = ((3 * CW + 56 + 7) / 8) * 8;
  localparam int     PAD_W       = TDATA_W - 3 * CW - 56;
  localparam int     CFG_W       = (ABITS > RANGE_BITS) ? ABITS : RANGE_BITS;
  localparam longint CMAX        = (longint'(1) << (CW - 1)) - 1;
  localparam longint CMIN        = -(longint'(1) << (CW - 1));
  localparam longint AMAX        = (longint'(1) << (ABITS - 1)) - 1;
  localparam longint AMIN        = -(longint'(1) << (ABITS - 1));
  localparam longint RMAX        = (longint'(1) << RANGE_BITS) - 1;
  localparam int     QUIET_LIMIT = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;

  int     mismatch_cnt;
  int     in_flight;
  int     checked_cnt;
  int     kept_cnt;
  int     src_idle_pct;
  int     sink_idle_pct;
  int     settings_cnt;
  int     quiet_cycles;
  longint cur_min;
  longint cur_max;
  longint l0, h0, l1, h1, l2, h2;
  longint mn, mx;

  always #1 clk_i = ~clk_i;

  lidar_range_sector_point_filter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // pos_x, pos_y, pos_z, reflect, tag_byte, scan_line, time_offset, zero pad
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // out_x, out_y, out_z, out_reflect, out_tag, out_line, out_time, zero pad
    .m_axis_tdata  (m_axis_tdata),
    // keep
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  lrsf_keep_checker #(
    .TDATA_W (TDATA_W),
    .CFG_W   (CFG_W)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tlast   (s_axis_tlast),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .mismatch_cnt_o (mismatch_cnt),
    .in_flight_o    (in_flight),
    .checked_cnt_o  (checked_cnt),
    .kept_cnt_o     (kept_cnt)
  );

  // Receiver back-pressure
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Watchdog: end the run after a long stretch with no beat moving
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic signed [CW-1:0] clamp_coord(input longint v);
    if (v > CMAX) return CMAX[CW-1:0];
    if (v < CMIN) return CMIN[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Sector bound with random junk above the angle bits
  function automatic logic [CFG_W-1:0] sector_word(input longint a);
    logic [CFG_W-1:0] w;
    longint           c;
    c = (a > AMAX) ? AMAX : ((a < AMIN) ? AMIN : a);
    w = CFG_W'($urandom);
    w[ABITS-1:0] = c[ABITS-1:0];
    return w;
  endfunction

  task automatic pick_sector(output longint lo, output longint hi);
    lo = longint'($urandom_range(0, 65535)) + AMIN;
    case ($urandom_range(0, 3))
      0: hi = lo - 1 - longint'($urandom_range(0, 2000));
      1: hi = lo + longint'($urandom_range(0, 512));
      2: hi = lo + longint'($urandom_range(0, 16384));
      default: hi = lo + longint'($urandom_range(0, 65535));
    endcase
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input longint min_r, input longint max_r,
                              input longint lo0, input longint hi0,
                              input longint lo1, input longint hi1,
                              input longint lo2, input longint hi2);
    put_reg(REG_MIN_RANGE, min_r[CFG_W-1:0]);
    put_reg(REG_MAX_RANGE, max_r[CFG_W-1:0]);
    put_reg(REG_SEC0_LOW, sector_word(lo0));
    put_reg(REG_SEC0_HIGH, sector_word(hi0));
    put_reg(REG_SEC1_LOW, sector_word(lo1));
    put_reg(REG_SEC1_HIGH, sector_word(hi1));
    put_reg(REG_SEC2_LOW, sector_word(lo2));
    put_reg(REG_SEC2_HIGH, sector_word(hi2));
    cfg_we_i <= 1'b0;
    cur_min = min_r;
    cur_max = max_r;
    settings_cnt++;
  endtask

  // Hold the sender until every point has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_point(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                            input logic signed [CW-1:0] z, input logic [7:0] refl,
                            input logic [7:0] tag, input logic [7:0] line,
                            input logic [31:0] tofs, input logic last);
    // Random gap before the beat
    if ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, tofs, line, tag, refl, z, y, x};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Directed point; side fields swing between their extremes
  task automatic send_probe(input longint x, input longint y, input int n);
    logic signed [CW-1:0] z;
    case (n % 3)
      0: z = '0;
      1: z = CMAX[CW-1:0];
      default: z = CMIN[CW-1:0];
    endcase
    send_point(clamp_coord(x), clamp_coord(y), z, n[0] ? 8'hFF : 8'h00,
               n[0] ? 8'h00 : 8'hFF, n[1] ? 8'hFF : 8'h00,
               n[0] ? 32'hFFFF_FFFF : 32'h0, n[0]);
  endtask

  // Random point, mostly aimed at range edges, axes and diagonals
  task automatic send_random_point();
    longint x;
    longint y;
    longint t;
    longint r;
    longint lo;
    longint hi;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        x = longint'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
        y = longint'($urandom_range(0, 2 * CMAX + 1)) + CMIN;
      end
      3, 4, 5, 6, 7, 8, 9: begin
        r = cur_max + cur_max / 8 + 16;
        if (r > CMAX) r = CMAX;
        x = longint'($urandom_range(0, 2 * r)) - r;
        y = longint'($urandom_range(0, 2 * r)) - r;
      end
      10, 11, 12, 13, 14, 15: begin
        r = ($urandom_range(0, 1) ? cur_min : cur_max) + longint'($urandom_range(0, 4)) - 2;
        x = r;
        y = longint'($urandom_range(0, 2));
        if ($urandom_range(0, 1)) begin
          t = x;
          x = y;
          y = t;
        end
      end
      default: begin
        lo = (cur_min < cur_max) ? cur_min : cur_max;
        hi = (cur_min < cur_max) ? cur_max : cur_min;
        r  = lo + longint'($urandom_range(0, hi - lo));
        case ($urandom_range(0, 2))
          0: begin x = r; y = 0; end
          1: begin x = 0; y = r; end
          default: begin x = r * 181 / 256; y = x; end
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) x = -x;
    if ($urandom_range(0, 1)) y = -y;
    send_point(clamp_coord(x), clamp_coord(y), CW'($urandom), 8'($urandom),
               8'($urandom), 8'($urandom), $urandom, $urandom_range(0, 15) == 0);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_point();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MIN_RANGE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_idle_pct  = 9;
    sink_idle_pct = 64;
    settings_cnt  = 1;
    cur_min       = MIN_RANGE_RST;
    cur_max       = MAX_RANGE_RST;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one point inside the minimum range, one kept
    send_probe(50, 0, 0);
    send_probe(150, -20, 1);
    wait_drained();

    // Range from zero to the largest limit; sectors on the zero angle, on pi and on +y
    program_regs(0, RMAX, 0, 0, AMAX, AMAX, AMAX / 2 + 1, AMAX / 2 + 1);
    send_probe(0, 0, 2);
    send_probe(1, 0, 3);
    send_probe(CMAX, 0, 4);
    send_probe(-1, 0, 5);
    send_probe(CMIN, 0, 6);
    send_probe(0, 1, 7);
    send_probe(0, CMIN, 8);
    send_probe(CMIN, CMIN, 9);
    send_probe(CMAX, CMAX, 10);
    send_probe(CMIN, CMAX, 11);
    send_probe(CMAX, CMIN, 12);
    send_probe(-7, 3, 13);
    send_probe(7, -3, 14);
    wait_drained();

    // Exact range edges; an empty sector and sectors at the angle extremes
    program_regs(1000, 2000, 100, -100, AMIN, AMIN, AMAX, AMAX);
    send_probe(1000, 0, 15);
    send_probe(999, 0, 16);
    send_probe(0, -1000, 17);
    send_probe(2000, 0, 18);
    send_probe(2001, 0, 19);
    send_probe(1200, 1600, 20);
    send_probe(1200, 1601, 21);
    send_probe(-600, 800, 22);
    send_probe(600, -799, 23);
    send_probe(-1414, -1414, 24);
    wait_drained();

    // Sender mostly busy, receiver mostly stalled
    pick_sector(l0, h0);
    pick_sector(l1, h1);
    pick_sector(l2, h2);
    program_regs(longint'($urandom_range(0, 3000)), longint'($urandom_range(8000, 60000)),
                 l0, h0, l1, h1, l2, h2);
    run_random(260);
    wait_drained();

    // Swap the idle mix; widest range and sectors hugging both angle limits
    src_idle_pct  = 64;
    sink_idle_pct = 9;
    pick_sector(l2, h2);
    program_regs(0, RMAX, AMIN, AMIN + longint'($urandom_range(0, 4000)),
                 AMAX - longint'($urandom_range(0, 4000)), AMAX, l2, h2);
    run_random(130);
    wait_drained();
    run_random(130);
    wait_drained();

    // No idling from here on
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    mn = longint'($urandom_range(0, 20000));
    mx = mn + longint'($urandom_range(0, 200000));
    if (mx > RMAX) mx = RMAX;
    pick_sector(l0, h0);
    pick_sector(l1, h1);
    pick_sector(l2, h2);
    program_regs(mn, mx, l0, h0, l1, h1, l2, h2);
    run_random(260);
    wait_drained();

    // Single ring: only points exactly on one radius pass
    mn = longint'($urandom_range(500, 5000));
    pick_sector(l2, h2);
    program_regs(mn, mn, AMAX, AMIN, AMAX, AMIN, l2, h2);
    run_random(250);

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (in_flight != 0);
    repeat (40) @(posedge clk_i);

    $display("%0d points checked (%0d kept) across %0d register settings",
             checked_cnt, kept_cnt, settings_cnt);
    $display("range edges, axes, diagonals and sector limits under three idle mixes");
    if (mismatch_cnt == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
